@@ design/i2cms_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cms_pkg
// shared types and constants for the i2c master bit sequencer
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [7:0] DelayTicksReset   = 8'd10;
  localparam logic [7:0] AckPollLimitReset = 8'd100;

  localparam logic [3:0] BitsPerByte = 4'd8;

  typedef enum logic [CfgIndexW-1:0] {
    REG_DELAY_TICKS    = 2'd0,
    REG_ACK_POLL_LIMIT = 2'd1
  } reg_index_t;

  typedef enum logic [2:0] {
    CMD_START     = 3'd0,
    CMD_STOP      = 3'd1,
    CMD_WRITE     = 3'd2,
    CMD_READ      = 3'd3,
    CMD_ACK       = 3'd4,
    CMD_NACK      = 3'd5,
    CMD_CHECK_ACK = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_S1   = 3'd1,
    PH_S2   = 3'd2,
    PH_S3   = 3'd3,
    PH_S4   = 3'd4,
    PH_S5   = 3'd5
  } phase_t;

endpackage

@@ design/i2c_master_bit_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit
// bit-banged i2c master pin sequencer, one bus tick per input word
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  tick     | tick_valid/tick_ready  | cmd_valid cmd tx_byte sda_in
//  result   | result_valid/          | scl sda_out sda_drive busy_res
//           |   result_ready         |   done_res rx_byte no_ack rejected
//  cfg      | cfg_valid/cfg_ready    | cfg_index cfg_data
//
//  one tick word per clock while tick_ready is high; the sequencer state and the
//  result word are updated together in the cycle the tick is taken, so the
//  result appears in the cycle after acceptance.
//  tick_ready is low only while a result word waits and result_ready is low.
//  cfg_ready is always high.
//  reset puts the bus pins at idle (scl, sda high, sda driven) and the
//  delay and poll registers at 10 and 100.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       tick_valid,
  output logic       tick_ready,
  input  logic       cmd_valid,
  input  logic [2:0] cmd,
  input  logic [7:0] tx_byte,
  input  logic       sda_in,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       scl,
  output logic       sda_out,
  output logic       sda_drive,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] rx_byte,
  output logic       no_ack,
  output logic       rejected,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [i2cms_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [i2cms_pkg::CfgDataW-1:0]  cfg_data
);

  logic [7:0] delay_ticks;
  logic [7:0] ack_poll_limit;

  i2cms_pkg::cmd_t   active_command, active_command_next;
  i2cms_pkg::phase_t phase, phase_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] delay_count, delay_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] poll_count, poll_count_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic       sda_output_mode, sda_output_mode_next;
  logic       ack_flag, ack_flag_next;
  logic [7:0] rx_last, rx_last_next;
  logic       done_flag, done_flag_next;
  logic       rej_flag, rej_flag_next;

  logic       take;
  logic [7:0] reload;
  logic [3:0] bit_inc;
  logic [7:0] poll_inc;

  assign tick_ready = !result_valid || result_ready;
  assign take       = tick_valid && tick_ready;
  assign cfg_ready  = 1'b1;
  assign reload     = (delay_ticks != 8'd0) ? delay_ticks - 8'd1 : 8'd0;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks    <= i2cms_pkg::DelayTicksReset;
      ack_poll_limit <= i2cms_pkg::AckPollLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        i2cms_pkg::REG_DELAY_TICKS:    delay_ticks    <= cfg_data;
        i2cms_pkg::REG_ACK_POLL_LIMIT: ack_poll_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state of the sequencer
  always_comb begin
    logic run;
    i2cms_pkg::cmd_t   c;
    i2cms_pkg::phase_t p;
    active_command_next  = active_command;
    phase_next           = phase;
    bit_index_next       = bit_index;
    delay_count_next     = delay_count;
    shift_byte_next      = shift_byte;
    poll_count_next      = poll_count;
    scl_level_next       = scl_level;
    sda_level_next       = sda_level;
    sda_output_mode_next = sda_output_mode;
    ack_flag_next        = ack_flag;
    rx_last_next         = rx_last;
    done_flag_next       = 1'b0;
    rej_flag_next        = 1'b0;
    run                  = 1'b0;
    bit_inc              = bit_index + 4'd1;
    poll_inc             = poll_count + 8'd1;

    if (phase == i2cms_pkg::PH_IDLE) begin
      if (cmd_valid && (cmd <= i2cms_pkg::CMD_CHECK_ACK)) begin
        active_command_next = i2cms_pkg::cmd_t'(cmd);
        phase_next          = i2cms_pkg::PH_S1;
        bit_index_next      = 4'd0;
        poll_count_next     = 8'd0;
        shift_byte_next     = (cmd == i2cms_pkg::CMD_WRITE) ? tx_byte : 8'd0;
        bit_inc             = 4'd1;
        poll_inc            = 8'd1;
        run                 = 1'b1;
      end
    end else begin
      rej_flag_next = cmd_valid;
      if (delay_count != 8'd0) begin
        delay_count_next = delay_count - 8'd1;
      end else begin
        run = 1'b1;
      end
    end

    c = active_command_next;
    p = phase_next;

    if (run) begin
      delay_count_next = reload;
      case (c)
        i2cms_pkg::CMD_START: begin
          if (p == i2cms_pkg::PH_S1) begin
            sda_output_mode_next = 1'b1;
            sda_level_next       = 1'b1;
            phase_next           = i2cms_pkg::PH_S2;
          end else if (p == i2cms_pkg::PH_S2) begin
            scl_level_next = 1'b1;
            phase_next     = i2cms_pkg::PH_S3;
          end else if (p == i2cms_pkg::PH_S3) begin
            sda_level_next = 1'b0;
            phase_next     = i2cms_pkg::PH_S4;
          end else if (p == i2cms_pkg::PH_S4) begin
            scl_level_next = 1'b0;
            phase_next     = i2cms_pkg::PH_S5;
          end else begin
            phase_next       = i2cms_pkg::PH_IDLE;
            delay_count_next = 8'd0;
            done_flag_next   = 1'b1;
          end
        end
        i2cms_pkg::CMD_STOP: begin
          if (p == i2cms_pkg::PH_S1) begin
            sda_output_mode_next = 1'b1;
            scl_level_next       = 1'b0;
            sda_level_next       = 1'b0;
            phase_next           = i2cms_pkg::PH_S2;
          end else if (p == i2cms_pkg::PH_S2) begin
            scl_level_next = 1'b1;
            phase_next     = i2cms_pkg::PH_S3;
          end else if (p == i2cms_pkg::PH_S3) begin
            sda_level_next = 1'b1;
            phase_next     = i2cms_pkg::PH_S4;
          end else begin
            phase_next       = i2cms_pkg::PH_IDLE;
            delay_count_next = 8'd0;
            done_flag_next   = 1'b1;
          end
        end
        i2cms_pkg::CMD_WRITE, i2cms_pkg::CMD_READ: begin
          if (p == i2cms_pkg::PH_S1) begin
            sda_output_mode_next = 1'b1;
            if (c == i2cms_pkg::CMD_WRITE) begin
              scl_level_next = 1'b0;
            end else begin
              sda_level_next = 1'b1;
            end
            phase_next = i2cms_pkg::PH_S2;
          end else if (p == i2cms_pkg::PH_S2) begin
            if (c == i2cms_pkg::CMD_WRITE) begin
              sda_level_next = shift_byte_next[7];
            end else begin
              sda_output_mode_next = 1'b0;
            end
            shift_byte_next = {shift_byte_next[6:0], 1'b0};
            scl_level_next  = 1'b1;
            phase_next      = i2cms_pkg::PH_S3;
          end else if (p == i2cms_pkg::PH_S3) begin
            if ((c == i2cms_pkg::CMD_READ) && sda_in) begin
              shift_byte_next = shift_byte_next | 8'h01;
            end
            scl_level_next = 1'b0;
            bit_index_next = bit_inc;
            phase_next     = (bit_inc < i2cms_pkg::BitsPerByte) ?
                             i2cms_pkg::PH_S2 : i2cms_pkg::PH_S4;
          end else begin
            if (c == i2cms_pkg::CMD_WRITE) begin
              sda_level_next = 1'b1;
            end else begin
              rx_last_next = shift_byte_next;
            end
            phase_next       = i2cms_pkg::PH_IDLE;
            delay_count_next = 8'd0;
            done_flag_next   = 1'b1;
          end
        end
        i2cms_pkg::CMD_ACK, i2cms_pkg::CMD_NACK: begin
          if (p == i2cms_pkg::PH_S1) begin
            sda_output_mode_next = 1'b1;
            scl_level_next       = 1'b0;
            sda_level_next       = (c == i2cms_pkg::CMD_NACK);
            phase_next           = i2cms_pkg::PH_S2;
          end else if (p == i2cms_pkg::PH_S2) begin
            scl_level_next = 1'b1;
            phase_next     = i2cms_pkg::PH_S3;
          end else begin
            scl_level_next   = 1'b0;
            phase_next       = i2cms_pkg::PH_IDLE;
            delay_count_next = 8'd0;
            done_flag_next   = 1'b1;
          end
        end
        default: begin
          if (p == i2cms_pkg::PH_S1) begin
            sda_output_mode_next = 1'b1;
            sda_level_next       = 1'b1;
            phase_next           = i2cms_pkg::PH_S2;
          end else if (p == i2cms_pkg::PH_S2) begin
            scl_level_next = 1'b1;
            phase_next     = i2cms_pkg::PH_S3;
          end else begin
            sda_output_mode_next = 1'b0;
            if (!sda_in) begin
              scl_level_next   = 1'b0;
              ack_flag_next    = 1'b0;
              phase_next       = i2cms_pkg::PH_IDLE;
              delay_count_next = 8'd0;
              done_flag_next   = 1'b1;
            end else begin
              poll_count_next = poll_inc;
              if (poll_inc >= ack_poll_limit) begin
                ack_flag_next    = 1'b1;
                phase_next       = i2cms_pkg::PH_IDLE;
                delay_count_next = 8'd0;
                done_flag_next   = 1'b1;
              end else begin
                phase_next       = i2cms_pkg::PH_S3;
                delay_count_next = 8'd0;
              end
            end
          end
        end
      endcase
    end
  end

  // result word
  always_comb begin
    scl       = scl_level;
    sda_out   = sda_level;
    sda_drive = sda_output_mode;
    busy_res  = (phase != i2cms_pkg::PH_IDLE);
    done_res  = done_flag;
    rx_byte   = rx_last;
    no_ack    = ack_flag;
    rejected  = rej_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid    <= 1'b0;
      active_command  <= i2cms_pkg::CMD_START;
      phase           <= i2cms_pkg::PH_IDLE;
      bit_index       <= 4'd0;
      delay_count     <= 8'd0;
      shift_byte      <= 8'd0;
      poll_count      <= 8'd0;
      scl_level       <= 1'b1;
      sda_level       <= 1'b1;
      sda_output_mode <= 1'b1;
      ack_flag        <= 1'b0;
      rx_last         <= 8'd0;
      done_flag       <= 1'b0;
      rej_flag        <= 1'b0;
    end else begin
      if (take) begin
        result_valid    <= 1'b1;
        active_command  <= active_command_next;
        phase           <= phase_next;
        bit_index       <= bit_index_next;
        delay_count     <= delay_count_next;
        shift_byte      <= shift_byte_next;
        poll_count      <= poll_count_next;
        scl_level       <= scl_level_next;
        sda_level       <= sda_level_next;
        sda_output_mode <= sda_output_mode_next;
        ack_flag        <= ack_flag_next;
        rx_last         <= rx_last_next;
        done_flag       <= done_flag_next;
        rej_flag        <= rej_flag_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sim/i2cms_tick_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_tick_checker
// watches the tick, result and cfg channels of the i2c master bit sequencer,
// steps its own model of the pin sequencer on every accepted tick word and
// compares each accepted result word against the oldest predicted pin word
// ----------------------------------------------------------------------------
module i2cms_tick_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tick_valid,
  input  logic                            tick_ready,
  input  logic                            cmd_valid,
  input  logic [2:0]                      cmd,
  input  logic [7:0]                      tx_byte,
  input  logic                            sda_in,
  input  logic                            result_valid,
  input  logic                            result_ready,
  input  logic                            scl,
  input  logic                            sda_out,
  input  logic                            sda_drive,
  input  logic                            busy_res,
  input  logic                            done_res,
  input  logic [7:0]                      rx_byte,
  input  logic                            no_ack,
  input  logic                            rejected,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [i2cms_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [i2cms_pkg::CfgDataW-1:0]  cfg_data,
  output int                              mismatches,
  output int                              words_pending
);

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       no_ack;
    logic       rejected;
  } pin_word_t;

  pin_word_t pin_words_q[$];

  logic [7:0] delay_cfg;
  logic [7:0] poll_cfg;

  i2cms_pkg::cmd_t   cur_cmd;
  i2cms_pkg::phase_t seq_phase;
  logic [3:0] bit_cnt;
  logic [7:0] hold_cnt;
  logic [7:0] shreg;
  logic [7:0] polls;
  logic       scl_q;
  logic       sda_q;
  logic       drive_q;
  logic       nack_q;
  logic [7:0] rx_q;
  logic       cmd_done;

  int fail_cnt = 0;
  int word_cnt = 0;

  function automatic void hold_then(input i2cms_pkg::phase_t nxt);
    seq_phase = nxt;
    hold_cnt  = (delay_cfg != 8'd0) ? delay_cfg - 8'd1 : 8'd0;
  endfunction

  function automatic void end_cmd();
    seq_phase = i2cms_pkg::PH_IDLE;
    hold_cnt  = 8'd0;
    cmd_done  = 1'b1;
  endfunction

  function automatic void advance_pins(input logic sd);
    case (cur_cmd)
      i2cms_pkg::CMD_START: begin
        case (seq_phase)
          i2cms_pkg::PH_S1: begin
            drive_q = 1'b1; sda_q = 1'b1; hold_then(i2cms_pkg::PH_S2);
          end
          i2cms_pkg::PH_S2: begin scl_q = 1'b1; hold_then(i2cms_pkg::PH_S3); end
          i2cms_pkg::PH_S3: begin sda_q = 1'b0; hold_then(i2cms_pkg::PH_S4); end
          i2cms_pkg::PH_S4: begin scl_q = 1'b0; hold_then(i2cms_pkg::PH_S5); end
          default: end_cmd();
        endcase
      end
      i2cms_pkg::CMD_STOP: begin
        case (seq_phase)
          i2cms_pkg::PH_S1: begin
            drive_q = 1'b1; scl_q = 1'b0; sda_q = 1'b0; hold_then(i2cms_pkg::PH_S2);
          end
          i2cms_pkg::PH_S2: begin scl_q = 1'b1; hold_then(i2cms_pkg::PH_S3); end
          i2cms_pkg::PH_S3: begin sda_q = 1'b1; hold_then(i2cms_pkg::PH_S4); end
          default: end_cmd();
        endcase
      end
      i2cms_pkg::CMD_WRITE: begin
        case (seq_phase)
          i2cms_pkg::PH_S1: begin
            drive_q = 1'b1; scl_q = 1'b0; hold_then(i2cms_pkg::PH_S2);
          end
          i2cms_pkg::PH_S2: begin
            sda_q = shreg[7];
            shreg = {shreg[6:0], 1'b0};
            scl_q = 1'b1;
            hold_then(i2cms_pkg::PH_S3);
          end
          i2cms_pkg::PH_S3: begin
            scl_q   = 1'b0;
            bit_cnt = bit_cnt + 4'd1;
            hold_then((bit_cnt < i2cms_pkg::BitsPerByte) ?
                      i2cms_pkg::PH_S2 : i2cms_pkg::PH_S4);
          end
          default: begin sda_q = 1'b1; end_cmd(); end
        endcase
      end
      i2cms_pkg::CMD_READ: begin
        case (seq_phase)
          i2cms_pkg::PH_S1: begin
            drive_q = 1'b1; sda_q = 1'b1; hold_then(i2cms_pkg::PH_S2);
          end
          i2cms_pkg::PH_S2: begin
            drive_q = 1'b0;
            shreg   = {shreg[6:0], 1'b0};
            scl_q   = 1'b1;
            hold_then(i2cms_pkg::PH_S3);
          end
          i2cms_pkg::PH_S3: begin
            if (sd) shreg[0] = 1'b1;
            scl_q   = 1'b0;
            bit_cnt = bit_cnt + 4'd1;
            hold_then((bit_cnt < i2cms_pkg::BitsPerByte) ?
                      i2cms_pkg::PH_S2 : i2cms_pkg::PH_S4);
          end
          default: begin rx_q = shreg; end_cmd(); end
        endcase
      end
      i2cms_pkg::CMD_ACK, i2cms_pkg::CMD_NACK: begin
        case (seq_phase)
          i2cms_pkg::PH_S1: begin
            drive_q = 1'b1;
            scl_q   = 1'b0;
            sda_q   = (cur_cmd == i2cms_pkg::CMD_NACK);
            hold_then(i2cms_pkg::PH_S2);
          end
          i2cms_pkg::PH_S2: begin scl_q = 1'b1; hold_then(i2cms_pkg::PH_S3); end
          default: begin scl_q = 1'b0; end_cmd(); end
        endcase
      end
      default: begin
        case (seq_phase)
          i2cms_pkg::PH_S1: begin
            drive_q = 1'b1; sda_q = 1'b1; hold_then(i2cms_pkg::PH_S2);
          end
          i2cms_pkg::PH_S2: begin scl_q = 1'b1; hold_then(i2cms_pkg::PH_S3); end
          default: begin
            drive_q = 1'b0;
            if (!sd) begin
              scl_q  = 1'b0;
              nack_q = 1'b0;
              end_cmd();
            end else begin
              polls = polls + 8'd1;
              if (polls >= poll_cfg) begin
                nack_q = 1'b1;
                end_cmd();
              end else begin
                seq_phase = i2cms_pkg::PH_S3;
                hold_cnt  = 8'd0;
              end
            end
          end
        endcase
      end
    endcase
  endfunction

  function automatic pin_word_t tick_sequencer(input logic cv, input logic [2:0] c,
                                               input logic [7:0] tx, input logic sd);
    pin_word_t w;
    logic      rej;
    rej      = 1'b0;
    cmd_done = 1'b0;
    if (seq_phase == i2cms_pkg::PH_IDLE) begin
      if (cv && c <= i2cms_pkg::CMD_CHECK_ACK) begin
        cur_cmd   = i2cms_pkg::cmd_t'(c);
        seq_phase = i2cms_pkg::PH_S1;
        bit_cnt   = 4'd0;
        polls     = 8'd0;
        shreg     = (c == i2cms_pkg::CMD_WRITE) ? tx : 8'd0;
        advance_pins(sd);
      end
    end else begin
      if (cv) rej = 1'b1;
      if (hold_cnt != 8'd0) hold_cnt = hold_cnt - 8'd1;
      else advance_pins(sd);
    end
    w.scl       = scl_q;
    w.sda_out   = sda_q;
    w.sda_drive = drive_q;
    w.busy      = (seq_phase != i2cms_pkg::PH_IDLE);
    w.done      = cmd_done;
    w.rx        = rx_q;
    w.no_ack    = nack_q;
    w.rejected  = rej;
    return w;
  endfunction

  always @(posedge clk) begin : monitor
    pin_word_t got;
    pin_word_t want;
    if (rst) begin
      delay_cfg = i2cms_pkg::DelayTicksReset;
      poll_cfg  = i2cms_pkg::AckPollLimitReset;
      cur_cmd   = i2cms_pkg::CMD_START;
      seq_phase = i2cms_pkg::PH_IDLE;
      bit_cnt   = 4'd0;
      hold_cnt  = 8'd0;
      shreg     = 8'd0;
      polls     = 8'd0;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      drive_q   = 1'b1;
      nack_q    = 1'b0;
      rx_q      = 8'd0;
      cmd_done  = 1'b0;
      pin_words_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == i2cms_pkg::REG_DELAY_TICKS) delay_cfg = cfg_data;
        else if (cfg_index == i2cms_pkg::REG_ACK_POLL_LIMIT) poll_cfg = cfg_data;
      end
      if (tick_valid && tick_ready)
        pin_words_q.push_back(tick_sequencer(cmd_valid, cmd, tx_byte, sda_in));
      if (result_valid && result_ready) begin
        got = {scl, sda_out, sda_drive, busy_res, done_res, rx_byte, no_ack, rejected};
        if (pin_words_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result word %0d arrived with nothing predicted: %p", word_cnt, got);
        end else begin
          want = pin_words_q.pop_front();
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("result word %0d differs", word_cnt);
              $display("  exp scl=%b sda=%b drv=%b busy=%b done=%b rx=%h nack=%b rej=%b",
                       want.scl, want.sda_out, want.sda_drive, want.busy, want.done,
                       want.rx, want.no_ack, want.rejected);
              $display("  act scl=%b sda=%b drv=%b busy=%b done=%b rx=%h nack=%b rej=%b",
                       got.scl, got.sda_out, got.sda_drive, got.busy, got.done,
                       got.rx, got.no_ack, got.rejected);
            end
          end
        end
        word_cnt++;
      end
    end
    mismatches    <= fail_cnt;
    words_pending <= pin_words_q.size();
  end

endmodule

@@ sim/i2c_master_bit_sequencer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit_tb
// drives bus tick words into the i2c master bit sequencer: a directed pass
// over every command and corner setting, then random tick streams under
// several delay and poll settings, with bursty input and a stalling result
// side; the checker beside the block predicts and compares every word
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit_tb;

  localparam int WatchdogLimit = 3000;
  localparam logic [i2cms_pkg::CfgIndexW-1:0] CfgIndexSpare = 2'd3;
  localparam logic [2:0] CmdUnused = 3'd7;

  typedef enum int {SDA_LOW, SDA_HIGH, SDA_RAND} sda_mode_t;

  logic                            clk;
  logic                            rst          = 1'b1;
  logic                            tick_valid   = 1'b0;
  logic                            tick_ready;
  logic                            cmd_valid    = 1'b0;
  logic [2:0]                      cmd          = i2cms_pkg::CMD_START;
  logic [7:0]                      tx_byte      = 8'd0;
  logic                            sda_in       = 1'b1;
  logic                            result_valid;
  logic                            result_ready = 1'b1;
  logic                            scl;
  logic                            sda_out;
  logic                            sda_drive;
  logic                            busy_res;
  logic                            done_res;
  logic [7:0]                      rx_byte;
  logic                            no_ack;
  logic                            rejected;
  logic                            cfg_valid    = 1'b0;
  logic                            cfg_ready;
  logic [i2cms_pkg::CfgIndexW-1:0] cfg_index    = i2cms_pkg::REG_DELAY_TICKS;
  logic [i2cms_pkg::CfgDataW-1:0]  cfg_data     = 8'd0;

  int   mismatches;
  int   words_pending;
  logic last_busy   = 1'b0;
  int   burst_left  = 0;
  int   ready_mode  = 0;
  int   ready_left  = 0;
  int   quiet_cycles = 0;

  i2c_master_bit_sequencer_unit u_dut (.*);

  i2cms_tick_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side stall pattern
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(20, 120);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: result_ready <= 1'b1;
      1: result_ready <= ~result_ready;
      2: result_ready <= 1'($urandom_range(0, 1));
      default: result_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (result_valid && result_ready) last_busy <= busy_res;
  end

  always @(posedge clk) begin
    if ((tick_valid && tick_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("i2c_master_bit_sequencer_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic pick_sda(input sda_mode_t m);
    case (m)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic send_tick(input logic cv, input logic [2:0] c, input logic [7:0] tx,
                           input logic sd);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        tick_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    tick_valid <= 1'b1;
    cmd_valid  <= cv;
    cmd        <= c;
    tx_byte    <= tx;
    sda_in     <= sd;
    do @(posedge clk); while (!tick_ready);
  endtask

  task automatic wait_drained();
    tick_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  // one word in flight until the sequencer reports idle; offers made here
  // always land on a busy sequencer and must be refused
  task automatic settle(input sda_mode_t m);
    forever begin
      wait_drained();
      if (!last_busy) break;
      send_tick($urandom_range(0, 5) == 0, 3'($urandom_range(0, 7)), 8'($urandom),
                pick_sda(m));
    end
  endtask

  task automatic run_cmd(input logic [2:0] c, input logic [7:0] tx, input sda_mode_t m);
    send_tick(1'b1, c, tx, pick_sda(m));
    settle(m);
  endtask

  task automatic write_reg(input logic [i2cms_pkg::CfgIndexW-1:0] idx,
                           input logic [7:0] val);
    settle(SDA_RAND);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_ticks(input int count);
    int        left;
    int        rate;
    sda_mode_t m;
    logic      cv;
    logic [2:0] c;
    left = 0;
    rate = 0;
    m    = SDA_RAND;
    repeat (count) begin
      if (left == 0) begin
        left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: rate = 3;
          1: rate = 10;
          2: rate = 30;
          default: rate = 100;
        endcase
        m = sda_mode_t'($urandom_range(0, 2));
      end
      left--;
      cv = ($urandom_range(1, 100) <= rate);
      c  = ($urandom_range(0, 15) == 0) ? CmdUnused : 3'($urandom_range(0, 6));
      send_tick(cv, c, 8'($urandom), pick_sda(m));
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    run_cmd(i2cms_pkg::CMD_START, 8'h00, SDA_RAND);
    run_cmd(i2cms_pkg::CMD_WRITE, 8'hA5, SDA_RAND);
    run_cmd(i2cms_pkg::CMD_READ, 8'h00, SDA_RAND);
    run_cmd(i2cms_pkg::CMD_CHECK_ACK, 8'h00, SDA_HIGH);
    run_cmd(i2cms_pkg::CMD_STOP, 8'h00, SDA_RAND);
    run_cmd(CmdUnused, 8'h00, SDA_RAND);

    // out of range index, then zero delay and zero poll limit
    write_reg(CfgIndexSpare, 8'h55);
    write_reg(i2cms_pkg::REG_DELAY_TICKS, 8'h00);
    write_reg(i2cms_pkg::REG_ACK_POLL_LIMIT, 8'h00);
    run_cmd(i2cms_pkg::CMD_CHECK_ACK, 8'h00, SDA_HIGH);
    run_cmd(i2cms_pkg::CMD_START, 8'h00, SDA_RAND);
    run_cmd(i2cms_pkg::CMD_WRITE, 8'h81, SDA_RAND);
    run_cmd(i2cms_pkg::CMD_WRITE, 8'h00, SDA_RAND);
    run_cmd(i2cms_pkg::CMD_WRITE, 8'hFF, SDA_RAND);
    run_cmd(i2cms_pkg::CMD_WRITE, 8'h5A, SDA_RAND);
    run_cmd(i2cms_pkg::CMD_READ, 8'h00, SDA_HIGH);
    run_cmd(i2cms_pkg::CMD_READ, 8'hFF, SDA_LOW);
    run_cmd(i2cms_pkg::CMD_READ, 8'h00, SDA_RAND);
    run_cmd(i2cms_pkg::CMD_ACK, 8'h00, SDA_RAND);
    run_cmd(i2cms_pkg::CMD_NACK, 8'h00, SDA_RAND);
    run_cmd(i2cms_pkg::CMD_CHECK_ACK, 8'h00, SDA_LOW);
    run_cmd(i2cms_pkg::CMD_CHECK_ACK, 8'h00, SDA_RAND);
    run_cmd(i2cms_pkg::CMD_STOP, 8'h00, SDA_RAND);
    random_ticks(120);

    write_reg(i2cms_pkg::REG_DELAY_TICKS, 8'd1);
    write_reg(i2cms_pkg::REG_ACK_POLL_LIMIT, 8'd1);
    random_ticks(120);

    write_reg(i2cms_pkg::REG_DELAY_TICKS, 8'd2);
    write_reg(i2cms_pkg::REG_ACK_POLL_LIMIT, 8'd255);
    run_cmd(i2cms_pkg::CMD_CHECK_ACK, 8'h00, SDA_HIGH);
    random_ticks(120);

    write_reg(i2cms_pkg::REG_DELAY_TICKS, 8'd255);
    write_reg(i2cms_pkg::REG_ACK_POLL_LIMIT, 8'd3);
    run_cmd(i2cms_pkg::CMD_NACK, 8'h00, SDA_RAND);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && words_pending == 0) begin
      $display("i2c_master_bit_sequencer_unit: match");
    end else begin
      $display("i2c_master_bit_sequencer_unit: mismatch");
    end
    $finish;
  end

endmodule
